[rtl/satl_pkg.sv]
`default_nettype none

package satl_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAY_COUNT_LOG2 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY         = 2'd3;

    // replacement policy codes
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    // result counter width
    localparam int COUNT_W = 32;

endpackage

`default_nettype wire

[rtl/satl_ram.sv]
`default_nettype none

module satl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/set_assoc_cache_tag_lookup_core.sv]
`default_nettype none

// Tag store of a set-associative cache with LRU or FIFO replacement.
// Configuration: pulse cfg_write with cfg_index / cfg_data while the block is idle;
// index 0 set index bits, 1 log2 of ways, 2 offset bits, 3 policy (0 LRU, 1 FIFO).
// An item (one address) is taken at a clock edge where start is high and busy low.
// The ways of the selected set are read one per cycle from a single line memory
// through one shared tag compare / age compare unit, each valid line's age written
// back the cycle after its read; ST_FINISH then picks the victim and writes the
// fill on a miss. done is high for exactly one cycle with hit, evicted, way_used
// and the running totals; the receiver cannot stall, so results are never held back.
// Sequence: after the accepting edge the ways are scanned in ST_SCAN, then ST_FINISH
// registers the result; done rises as the block returns to idle, and start may be
// taken again in the done cycle, so one item is finished before the next is taken.
// Reset: a clearing pass writes every line and every FIFO pointer to zero, one
// entry per cycle over all 2^MAX_SET_BITS * MAX_WAYS lines (512 by default); busy
// stays high until it is done. Configuration writes are taken during the pass.
// Line contents persist across configuration changes; nothing is flushed.
module set_assoc_cache_tag_lookup_core #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64,
    parameter int AGE_WIDTH    = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [63:0]                    address,
    input  wire logic                           cfg_write,
    input  wire logic [satl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [satl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                done,
    output logic                                hit,
    output logic                                evicted,
    output logic [2:0]                          way_used,
    output logic [satl_pkg::COUNT_W-1:0]        hit_total,
    output logic [satl_pkg::COUNT_W-1:0]        miss_total,
    output logic [satl_pkg::COUNT_W-1:0]        evict_total
);

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
    localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int LINE_AW   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW_RAW    = $clog2(MAX_WAYS + 1);
    localparam int CW        = (CW_RAW > 4) ? CW_RAW : 4;
    localparam int LINE_W    = 1 + ADDR_WIDTH + AGE_WIDTH;
    localparam int CNT_W     = satl_pkg::COUNT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // configuration
    logic [2:0] set_index_bits_reg, set_index_bits_next;
    logic [1:0] way_count_log2_reg, way_count_log2_next;
    logic [5:0] offset_bits_reg, offset_bits_next;
    logic       policy_reg, policy_next;

    // sequencer and item state
    state_t                state_reg, state_next;
    logic [LINE_AW-1:0]    clr_reg, clr_next;
    logic [SET_AW-1:0]     set_reg, set_next;
    logic [LINE_AW-1:0]    base_reg, base_next;
    logic [ADDR_WIDTH-1:0] tag_reg, tag_next;
    logic [CW-1:0]         ways_reg, ways_next;
    logic [CW-1:0]         rd_way_reg, rd_way_next;
    logic                  pv_reg, pv_next;
    logic [WAY_BITS-1:0]   pw_reg, pw_next;

    // scan results
    logic                  hit_reg, hit_next;
    logic [WAY_BITS-1:0]   hit_way_reg, hit_way_next;
    logic                  have_empty_reg, have_empty_next;
    logic [WAY_BITS-1:0]   empty_way_reg, empty_way_next;
    logic                  have_lru_reg, have_lru_next;
    logic [WAY_BITS-1:0]   lru_way_reg, lru_way_next;
    logic [AGE_WIDTH-1:0]  best_age_reg, best_age_next;
    logic [MAX_WAYS-1:0]   seen_valid_reg, seen_valid_next;

    // totals and result
    logic [CNT_W-1:0]      hit_count_reg, hit_count_next;
    logic [CNT_W-1:0]      miss_count_reg, miss_count_next;
    logic [CNT_W-1:0]      evict_count_reg, evict_count_next;
    logic                  done_reg, done_next;
    logic                  hit_out_reg, hit_out_next;
    logic                  evicted_reg, evicted_next;
    logic [2:0]            way_used_reg, way_used_next;

    // memory ports
    logic                  line_we, line_re;
    logic [LINE_AW-1:0]    line_waddr, line_raddr;
    logic [LINE_W-1:0]     line_wdata, line_rdata;
    logic                  fifo_we, fifo_re;
    logic [SET_AW-1:0]     fifo_waddr, fifo_raddr;
    logic [WAY_BITS-1:0]   fifo_wdata, fifo_rdata;

    // address decode for an incoming item
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [3:0]            sbits;
    logic [ADDR_WIDTH-1:0] shifted_set;
    logic [SET_AW-1:0]     set_mask;
    logic [SET_AW-1:0]     set_calc;
    logic [6:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] tag_calc;
    logic [CW-1:0]         ways_pow;
    logic [CW-1:0]         ways_calc;

    // shared compare unit signals
    logic                  rd_valid;
    logic [ADDR_WIDTH-1:0] rd_tag;
    logic [AGE_WIDTH-1:0]  rd_age;
    logic                  rd_match;
    logic [AGE_WIDTH-1:0]  age_new;
    logic                  issue;

    // victim selection
    logic [WAY_BITS-1:0]   fifo_victim;
    logic [WAY_BITS-1:0]   victim;
    logic [CW-1:0]         victim_inc;
    logic                  evict_now;

    satl_ram #(
        .WIDTH (LINE_W),
        .DEPTH (NUM_LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    satl_ram #(
        .WIDTH (WAY_BITS),
        .DEPTH (NUM_SETS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // set index and tag from the incoming address
    always_comb
    begin
        addr_in     = address[ADDR_WIDTH-1:0];
        sbits       = (int'(set_index_bits_reg) > MAX_SET_BITS) ? 4'(MAX_SET_BITS)
                                                                 : {1'b0, set_index_bits_reg};
        shifted_set = addr_in >> offset_bits_reg;
        set_mask    = ~({SET_AW{1'b1}} << sbits);
        set_calc    = shifted_set[SET_AW-1:0] & set_mask;
        tag_shift   = 7'(offset_bits_reg) + 7'(sbits);
        tag_calc    = addr_in >> tag_shift;
        ways_pow    = CW'(1) << way_count_log2_reg;
        ways_calc   = (ways_pow > CW'(MAX_WAYS)) ? CW'(MAX_WAYS) : ways_pow;
    end

    // line fields and age update
    always_comb
    begin
        rd_valid = line_rdata[LINE_W-1];
        rd_tag   = line_rdata[AGE_WIDTH +: ADDR_WIDTH];
        rd_age   = line_rdata[AGE_WIDTH-1:0];
        rd_match = rd_valid && (rd_tag == tag_reg);
        age_new  = (&rd_age) ? rd_age : rd_age + AGE_WIDTH'(1);
        if (rd_match)
        begin
            age_new = '0;
        end
    end

    // victim choice at the end of the scan
    always_comb
    begin
        fifo_victim = (ways_reg == CW'(MAX_WAYS)) ? fifo_rdata
                                                  : fifo_rdata & WAY_BITS'(ways_reg - CW'(1));
        if (hit_reg)
        begin
            victim = hit_way_reg;
        end
        else if (policy_reg == satl_pkg::POLICY_FIFO)
        begin
            victim = fifo_victim;
        end
        else if (have_empty_reg)
        begin
            victim = empty_way_reg;
        end
        else
        begin
            victim = lru_way_reg;
        end
        victim_inc = CW'(victim) + CW'(1);
        evict_now  = !hit_reg && seen_valid_reg[victim];
    end

    assign issue = (rd_way_reg < ways_reg);

    // sequencer
    always_comb
    begin
        set_index_bits_next = set_index_bits_reg;
        way_count_log2_next = way_count_log2_reg;
        offset_bits_next    = offset_bits_reg;
        policy_next         = policy_reg;
        state_next          = state_reg;
        clr_next            = clr_reg;
        set_next            = set_reg;
        base_next           = base_reg;
        tag_next            = tag_reg;
        ways_next           = ways_reg;
        rd_way_next         = rd_way_reg;
        pv_next             = 1'b0;
        pw_next             = pw_reg;
        hit_next            = hit_reg;
        hit_way_next        = hit_way_reg;
        have_empty_next     = have_empty_reg;
        empty_way_next      = empty_way_reg;
        have_lru_next       = have_lru_reg;
        lru_way_next        = lru_way_reg;
        best_age_next       = best_age_reg;
        seen_valid_next     = seen_valid_reg;
        hit_count_next      = hit_count_reg;
        miss_count_next     = miss_count_reg;
        evict_count_next    = evict_count_reg;
        done_next           = 1'b0;
        hit_out_next        = hit_out_reg;
        evicted_next        = evicted_reg;
        way_used_next       = way_used_reg;

        line_we    = 1'b0;
        line_waddr = '0;
        line_wdata = '0;
        line_re    = 1'b0;
        line_raddr = base_reg + LINE_AW'(rd_way_reg[WAY_BITS-1:0]);
        fifo_we    = 1'b0;
        fifo_waddr = set_reg;
        fifo_wdata = '0;
        fifo_re    = 1'b0;
        fifo_raddr = set_calc;

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                satl_pkg::REG_SET_INDEX_BITS: set_index_bits_next = cfg_data[2:0];
                satl_pkg::REG_WAY_COUNT_LOG2: way_count_log2_next = cfg_data[1:0];
                satl_pkg::REG_OFFSET_BITS:    offset_bits_next    = cfg_data[5:0];
                satl_pkg::REG_POLICY:         policy_next         = cfg_data[0];
                default:                      ;
            endcase
        end

        unique case (state_reg)
            // zero every line and pointer after reset
            ST_CLEAR:
            begin
                line_we    = 1'b1;
                line_waddr = clr_reg;
                if (int'(clr_reg) < NUM_SETS)
                begin
                    fifo_we    = 1'b1;
                    fifo_waddr = SET_AW'(clr_reg);
                end
                clr_next = clr_reg + LINE_AW'(1);
                if (clr_reg == LINE_AW'(NUM_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take an item, fetch the set's fifo pointer
            ST_IDLE:
            begin
                if (start)
                begin
                    set_next        = set_calc;
                    base_next       = LINE_AW'(set_calc) * LINE_AW'(MAX_WAYS);
                    tag_next        = tag_calc;
                    ways_next       = ways_calc;
                    rd_way_next     = '0;
                    hit_next        = 1'b0;
                    hit_way_next    = '0;
                    have_empty_next = 1'b0;
                    empty_way_next  = '0;
                    have_lru_next   = 1'b0;
                    lru_way_next    = '0;
                    best_age_next   = '0;
                    seen_valid_next = '0;
                    fifo_re         = 1'b1;
                    state_next      = ST_SCAN;
                end
            end

            // read one way per cycle, evaluate the previous one and write its age back
            ST_SCAN:
            begin
                if (issue)
                begin
                    line_re     = 1'b1;
                    rd_way_next = rd_way_reg + CW'(1);
                    pv_next     = 1'b1;
                    pw_next     = rd_way_reg[WAY_BITS-1:0];
                end
                else
                begin
                    state_next = ST_FINISH;
                end
                if (pv_reg)
                begin
                    seen_valid_next[pw_reg] = rd_valid;
                    if (rd_valid)
                    begin
                        line_we    = 1'b1;
                        line_waddr = base_reg + LINE_AW'(pw_reg);
                        line_wdata = {1'b1, rd_tag, age_new};
                    end
                    if (rd_match)
                    begin
                        if (!hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_way_next = pw_reg;
                        end
                    end
                    else if (rd_valid)
                    begin
                        if (!have_lru_reg || (rd_age > best_age_reg))
                        begin
                            have_lru_next = 1'b1;
                            best_age_next = rd_age;
                            lru_way_next  = pw_reg;
                        end
                    end
                    else if (!have_empty_reg)
                    begin
                        have_empty_next = 1'b1;
                        empty_way_next  = pw_reg;
                    end
                end
            end

            // fill on a miss, update totals, present the result
            ST_FINISH:
            begin
                if (hit_reg)
                begin
                    hit_count_next = (&hit_count_reg) ? hit_count_reg
                                                      : hit_count_reg + CNT_W'(1);
                end
                else
                begin
                    miss_count_next = (&miss_count_reg) ? miss_count_reg
                                                        : miss_count_reg + CNT_W'(1);
                    line_we    = 1'b1;
                    line_waddr = base_reg + LINE_AW'(victim);
                    line_wdata = {1'b1, tag_reg, {AGE_WIDTH{1'b0}}};
                    if (policy_reg == satl_pkg::POLICY_FIFO)
                    begin
                        fifo_we    = 1'b1;
                        fifo_wdata = (victim_inc == ways_reg) ? '0 : WAY_BITS'(victim_inc);
                    end
                end
                if (evict_now)
                begin
                    evict_count_next = (&evict_count_reg) ? evict_count_reg
                                                          : evict_count_reg + CNT_W'(1);
                end
                hit_out_next  = hit_reg;
                evicted_next  = evict_now;
                way_used_next = 3'(victim);
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_index_bits_reg <= '0;
            way_count_log2_reg <= '0;
            offset_bits_reg    <= '0;
            policy_reg         <= satl_pkg::POLICY_LRU;
            state_reg          <= ST_CLEAR;
            clr_reg            <= '0;
            set_reg            <= '0;
            base_reg           <= '0;
            tag_reg            <= '0;
            ways_reg           <= '0;
            rd_way_reg         <= '0;
            pv_reg             <= 1'b0;
            pw_reg             <= '0;
            hit_reg            <= 1'b0;
            hit_way_reg        <= '0;
            have_empty_reg     <= 1'b0;
            empty_way_reg      <= '0;
            have_lru_reg       <= 1'b0;
            lru_way_reg        <= '0;
            best_age_reg       <= '0;
            seen_valid_reg     <= '0;
            hit_count_reg      <= '0;
            miss_count_reg     <= '0;
            evict_count_reg    <= '0;
            done_reg           <= 1'b0;
            hit_out_reg        <= 1'b0;
            evicted_reg        <= 1'b0;
            way_used_reg       <= '0;
        end
        else
        begin
            set_index_bits_reg <= set_index_bits_next;
            way_count_log2_reg <= way_count_log2_next;
            offset_bits_reg    <= offset_bits_next;
            policy_reg         <= policy_next;
            state_reg          <= state_next;
            clr_reg            <= clr_next;
            set_reg            <= set_next;
            base_reg           <= base_next;
            tag_reg            <= tag_next;
            ways_reg           <= ways_next;
            rd_way_reg         <= rd_way_next;
            pv_reg             <= pv_next;
            pw_reg             <= pw_next;
            hit_reg            <= hit_next;
            hit_way_reg        <= hit_way_next;
            have_empty_reg     <= have_empty_next;
            empty_way_reg      <= empty_way_next;
            have_lru_reg       <= have_lru_next;
            lru_way_reg        <= lru_way_next;
            best_age_reg       <= best_age_next;
            seen_valid_reg     <= seen_valid_next;
            hit_count_reg      <= hit_count_next;
            miss_count_reg     <= miss_count_next;
            evict_count_reg    <= evict_count_next;
            done_reg           <= done_next;
            hit_out_reg        <= hit_out_next;
            evicted_reg        <= evicted_next;
            way_used_reg       <= way_used_next;
        end
    end

    // ports
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_out_reg;
    assign evicted     = evicted_reg;
    assign way_used    = way_used_reg;
    assign hit_total   = hit_count_reg;
    assign miss_total  = miss_count_reg;
    assign evict_total = evict_count_reg;

endmodule

`default_nettype wire

[test/tb_set_assoc_cache_tag_lookup_core.sv]
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_lookup_core;

    localparam int MAX_SET_BITS  = 6;
    localparam int MAX_WAYS      = 8;
    localparam int NUM_SETS      = 1 << MAX_SET_BITS;
    localparam int NUM_LINES     = NUM_SETS * MAX_WAYS;
    localparam logic [31:0] AGE_TOP   = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int SLOW_FROM     = 340;
    localparam int FAST_FROM     = 680;

    typedef enum logic [1:0] {OP_ACCESS, OP_CONFIG, OP_SETTLE} op_kind_t;

    typedef struct {
        op_kind_t                           kind;
        logic [63:0]                        addr;
        logic [satl_pkg::CFG_INDEX_W-1:0]   reg_index;
        logic [satl_pkg::CFG_DATA_W-1:0]    reg_data;
    } pending_op_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [2:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } lookup_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic [63:0]                      address = '0;
    logic                             cfg_write = 1'b0;
    logic [satl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [satl_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             busy;
    logic                             done;
    logic                             hit;
    logic                             evicted;
    logic [2:0]                       way_used;
    logic [satl_pkg::COUNT_W-1:0]     hit_total;
    logic [satl_pkg::COUNT_W-1:0]     miss_total;
    logic [satl_pkg::COUNT_W-1:0]     evict_total;

    pending_op_t    op_q[$];
    lookup_result_t lookup_q[$];
    int unsigned    mismatch_count = 0;
    int unsigned    accesses_taken = 0;
    int unsigned    in_flight = 0;

    // predictor copy of the configuration
    logic [2:0] cfg_set_bits = '0;
    logic [1:0] cfg_way_log2 = '0;
    logic [5:0] cfg_offset = '0;
    logic       cfg_policy = satl_pkg::POLICY_LRU;

    // predictor copy of the tag store
    logic        way_valid [NUM_LINES] = '{default: 1'b0};
    logic [63:0] way_tag [NUM_LINES] = '{default: 64'd0};
    logic [31:0] way_age [NUM_LINES] = '{default: 32'd0};
    int unsigned fifo_ptr [NUM_SETS];
    logic [31:0] hits_so_far = '0;
    logic [31:0] misses_so_far = '0;
    logic [31:0] evicts_so_far = '0;

    set_assoc_cache_tag_lookup_core #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS),
        .ADDR_WIDTH(64),
        .AGE_WIDTH(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .address(address),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .hit(hit),
        .evicted(evicted),
        .way_used(way_used),
        .hit_total(hit_total),
        .miss_total(miss_total),
        .evict_total(evict_total)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] bump(input logic [31:0] v, input logic [31:0] top);
        return (v < top) ? v + 32'd1 : top;
    endfunction

    // look up one address in the predicted store, refill on a miss
    function automatic lookup_result_t lookup_and_fill(input logic [63:0] addr);
        int unsigned    sbits;
        int unsigned    ways;
        int unsigned    set_no;
        int unsigned    shift;
        int unsigned    base;
        int unsigned    victim;
        int unsigned    hit_way;
        int unsigned    empty_way;
        int unsigned    lru_way;
        int unsigned    w;
        logic [63:0]    tag;
        logic [31:0]    best_age;
        bit             found;
        bit             have_empty;
        bit             have_lru;
        bit             replaced;
        lookup_result_t r;

        sbits = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
        ways = 1 << cfg_way_log2;
        if (ways > MAX_WAYS)
            ways = MAX_WAYS;
        set_no = 32'((addr >> cfg_offset) & ((64'd1 << sbits) - 64'd1));
        shift = cfg_offset + sbits;
        tag = (shift >= 64) ? 64'd0 : (addr >> shift);
        base = set_no * MAX_WAYS;
        found = 0;
        have_empty = 0;
        have_lru = 0;
        replaced = 0;
        hit_way = 0;
        empty_way = 0;
        lru_way = 0;
        best_age = '0;

        // search the ways in use, aging every other valid line
        for (w = 0; w < ways; w++)
        begin
            if (way_valid[base + w] && way_tag[base + w] == tag)
            begin
                if (!found)
                begin
                    found = 1;
                    hit_way = w;
                end
                way_age[base + w] = '0;
            end
            else if (way_valid[base + w])
            begin
                if (!have_lru || way_age[base + w] > best_age)
                begin
                    have_lru = 1;
                    best_age = way_age[base + w];
                    lru_way = w;
                end
                way_age[base + w] = bump(way_age[base + w], AGE_TOP);
            end
            else if (!have_empty)
            begin
                have_empty = 1;
                empty_way = w;
            end
        end

        if (found)
        begin
            hits_so_far = bump(hits_so_far, COUNT_TOP);
            victim = hit_way;
        end
        else
        begin
            misses_so_far = bump(misses_so_far, COUNT_TOP);
            if (cfg_policy == satl_pkg::POLICY_FIFO)
            begin
                victim = fifo_ptr[set_no] % ways;
                fifo_ptr[set_no] = (victim + 1) % ways;
            end
            else
                victim = have_empty ? empty_way : lru_way;
            if (way_valid[base + victim])
            begin
                replaced = 1;
                evicts_so_far = bump(evicts_so_far, COUNT_TOP);
            end
            way_valid[base + victim] = 1'b1;
            way_tag[base + victim] = tag;
            way_age[base + victim] = '0;
        end

        r.hit = found;
        r.evicted = replaced;
        r.way = 3'(victim);
        r.hits = hits_so_far;
        r.misses = misses_so_far;
        r.evicts = evicts_so_far;
        return r;
    endfunction

    // item driver: accesses, register writes and pauses until the block drains
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic                             next_start;
        logic                             next_write;
        logic [63:0]                      next_addr;
        logic [satl_pkg::CFG_INDEX_W-1:0] next_index;
        logic [satl_pkg::CFG_DATA_W-1:0]  next_data;
        int unsigned                      idle_pct;
        int unsigned                      settle_left;
        pending_op_t                      head;

        if (!rst_n)
        begin
            start <= 1'b0;
            address <= '0;
            cfg_write <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            settle_left = 0;
        end
        else
        begin
            next_start = start;
            next_write = 1'b0;
            next_addr = address;
            next_index = cfg_index;
            next_data = cfg_data;
            if (done)
                in_flight--;

            // item taken this edge
            if (start && !busy)
            begin
                lookup_q.push_back(lookup_and_fill(address));
                in_flight++;
                accesses_taken++;
                next_start = 1'b0;
            end

            idle_pct = (accesses_taken < SLOW_FROM) ? 18 :
                       (accesses_taken < FAST_FROM) ? 84 : 0;

            if (settle_left > 0)
                settle_left--;
            else if (!next_start && op_q.size() > 0)
            begin
                head = op_q[0];
                case (head.kind)
                    OP_ACCESS:
                    begin
                        if ($urandom_range(0, 99) >= idle_pct)
                        begin
                            void'(op_q.pop_front());
                            next_start = 1'b1;
                            next_addr = head.addr;
                        end
                    end
                    OP_CONFIG:
                    begin
                        void'(op_q.pop_front());
                        next_write = 1'b1;
                        next_index = head.reg_index;
                        next_data = head.reg_data;
                        case (head.reg_index)
                            satl_pkg::REG_SET_INDEX_BITS: cfg_set_bits = head.reg_data[2:0];
                            satl_pkg::REG_WAY_COUNT_LOG2: cfg_way_log2 = head.reg_data[1:0];
                            satl_pkg::REG_OFFSET_BITS:    cfg_offset = head.reg_data[5:0];
                            satl_pkg::REG_POLICY:         cfg_policy = head.reg_data[0];
                            default:                      ;
                        endcase
                    end
                    OP_SETTLE:
                    begin
                        if (in_flight == 0)
                        begin
                            void'(op_q.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    default: ;
                endcase
            end

            start <= next_start;
            address <= next_addr;
            cfg_write <= next_write;
            cfg_index <= next_index;
            cfg_data <= next_data;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // result checker
    always @(posedge clk)
    begin : check
        lookup_result_t want;

        if (rst_n && done)
        begin
            if (lookup_q.size() == 0)
                note_mismatch($sformatf("unexpected result at %0t: hit=%0d evicted=%0d way=%0d",
                                        $realtime, hit, evicted, way_used));
            else
            begin
                want = lookup_q.pop_front();
                if (hit !== want.hit || evicted !== want.evicted || way_used !== want.way ||
                    hit_total !== want.hits || miss_total !== want.misses ||
                    evict_total !== want.evicts)
                    note_mismatch($sformatf({"mismatch at %0t: expected hit=%0d evicted=%0d",
                        " way=%0d totals=%0d/%0d/%0d, got hit=%0d evicted=%0d way=%0d",
                        " totals=%0d/%0d/%0d"}, $realtime, want.hit, want.evicted, want.way,
                        want.hits, want.misses, want.evicts, hit, evicted, way_used,
                        hit_total, miss_total, evict_total));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin : watchdog
        int unsigned quiet_cycles;

        if (!rst_n)
            quiet_cycles = 0;
        else if ((start && !busy) || done || cfg_write)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_access(input logic [63:0] addr);
        pending_op_t op;
        op.kind = OP_ACCESS;
        op.addr = addr;
        op.reg_index = '0;
        op.reg_data = '0;
        op_q.push_back(op);
    endtask

    task automatic queue_settle();
        pending_op_t op;
        op.kind = OP_SETTLE;
        op.addr = '0;
        op.reg_index = '0;
        op.reg_data = '0;
        op_q.push_back(op);
    endtask

    // register write with random junk above the register's own width
    task automatic queue_write(input logic [satl_pkg::CFG_INDEX_W-1:0] idx,
                               input int unsigned value, input int unsigned width);
        pending_op_t op;
        op.kind = OP_CONFIG;
        op.addr = '0;
        op.reg_index = idx;
        op.reg_data = satl_pkg::CFG_DATA_W'(($urandom << width) | value);
        op_q.push_back(op);
    endtask

    // drain the block, then write all four registers
    task automatic queue_setting(input int unsigned sb, input int unsigned wl,
                                 input int unsigned off, input logic pol);
        queue_settle();
        queue_write(satl_pkg::REG_SET_INDEX_BITS, sb, 3);
        queue_write(satl_pkg::REG_WAY_COUNT_LOG2, wl, 2);
        queue_write(satl_pkg::REG_OFFSET_BITS, off, 6);
        queue_write(satl_pkg::REG_POLICY, pol, 1);
    endtask

    function automatic logic [63:0] compose_address(input logic [63:0] tag,
                                                    input int unsigned set_no,
                                                    input logic [63:0] low,
                                                    input int unsigned sb,
                                                    input int unsigned off);
        int unsigned sbe;
        sbe = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
        return (tag << (off + sbe)) | (64'(set_no) << off) | (low & ((64'd1 << off) - 64'd1));
    endfunction

    initial
    begin
        int unsigned sb;
        int unsigned wl;
        int unsigned off;
        int unsigned sbe;
        int unsigned phase;
        int unsigned span;
        int unsigned n;
        int unsigned pick;
        int unsigned used_sets;
        int unsigned tags_per_set;
        int unsigned planned;
        logic        pol;
        logic [63:0] pool_tag[$];
        int unsigned pool_set[$];
        logic [63:0] t;

        // plain single-line store, extreme addresses
        queue_setting(0, 0, 0, satl_pkg::POLICY_LRU);
        queue_access(64'd0);
        queue_access(64'd0);
        queue_access(64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(64'h8000_0000_0000_0000);
        queue_access(64'h8000_0000_0000_0000);

        // set index wider than the store, eight ways, tag shifted out entirely
        queue_setting(7, 3, 63, satl_pkg::POLICY_FIFO);
        queue_access(64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(64'h8000_0000_0000_0000);
        queue_access(64'd0);
        queue_access(64'd1);

        // four-way LRU: fill a set, evict the oldest, hit, evict again
        queue_setting(1, 2, 2, satl_pkg::POLICY_LRU);
        for (n = 1; n <= 5; n++)
            queue_access(compose_address(64'(n), 1, 64'd3, 1, 2));
        queue_access(compose_address(64'd2, 1, 64'd0, 1, 2));
        queue_access(compose_address(64'd1, 1, 64'd1, 1, 2));
        queue_access(compose_address(64'd9, 0, 64'd2, 1, 2));

        // two-way FIFO: pointer wraps and evicts
        queue_setting(0, 1, 0, satl_pkg::POLICY_FIFO);
        queue_access(64'd10);
        queue_access(64'd20);
        queue_access(64'd30);
        queue_access(64'd10);
        queue_access(64'd20);

        // random phases, each with its own geometry and a small working set
        planned = 0;
        phase = 0;
        while (planned < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin sb = 7; wl = 3; off = 63; pol = satl_pkg::POLICY_FIFO; end
                1: begin sb = 0; wl = 0; off = 0;  pol = satl_pkg::POLICY_LRU;  end
                2: begin sb = 6; wl = 3; off = 0;  pol = satl_pkg::POLICY_LRU;  end
                3: begin sb = 2; wl = 3; off = 57; pol = satl_pkg::POLICY_FIFO; end
                default:
                begin
                    sb = $urandom_range(0, 7);
                    wl = $urandom_range(0, 3);
                    off = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 63)
                                                      : $urandom_range(0, 12);
                    pol = $urandom_range(0, 1);
                end
            endcase
            phase++;
            queue_setting(sb, wl, off, pol);

            sbe = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
            used_sets = $urandom_range(1, ((1 << sbe) < 4) ? (1 << sbe) : 4);
            tags_per_set = $urandom_range(1, (1 << wl) + 2);
            pool_tag.delete();
            pool_set.delete();
            for (n = 0; n < used_sets; n++)
            begin
                pick = $urandom_range(0, (1 << sbe) - 1);
                for (int unsigned k = 0; k < tags_per_set; k++)
                begin
                    t = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                    : 64'($urandom_range(0, 15));
                    pool_tag.push_back(t);
                    pool_set.push_back(pick);
                end
            end

            span = $urandom_range(40, 120);
            for (n = 0; n < span; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    queue_settle();
                if ($urandom_range(0, 9) == 0)
                    queue_access({$urandom, $urandom});
                else
                begin
                    pick = $urandom_range(0, pool_tag.size() - 1);
                    queue_access(compose_address(pool_tag[pick], pool_set[pick],
                                                 {$urandom, $urandom}, sb, off));
                end
            end
            planned += span;
        end

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for the last item and its result, then let the block settle
        while (op_q.size() != 0 || start || lookup_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/satl_pkg.sv
rtl/satl_ram.sv
rtl/set_assoc_cache_tag_lookup_core.sv
test/tb_set_assoc_cache_tag_lookup_core.sv
